>>> src/tfn_pkg.sv
// Shared constants for the triangle face normal block.
// No dependencies; every other file of the block imports this package.
package tfn_pkg;
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int FIELD_W              = 16;
    localparam int IN_FIELDS            = 9;
    localparam int IN_DATA_W            = FIELD_W * IN_FIELDS;
    localparam int OUT_DATA_W           = FIELD_W * 3;
    localparam int QUEUE_DEPTH          = 4;
endpackage

>>> src/tfn_front.sv
// Front end: edge vectors, exact cross product and the degenerate check.
// Depends on tfn_pkg.
module tfn_front
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int NW = 2 * (COORD_WIDTH + 1) + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IN_DATA_W-1:0] i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [3*NW:0]        o_data     // nx, ny, nz, degenerate
);
    localparam int EW = COORD_WIDTH + 1;
    localparam int PW = 2 * EW;

    logic signed [COORD_WIDTH-1:0] w_c [IN_FIELDS];
    logic signed [EW-1:0] r_e [6];      // ux, uy, uz, vx, vy, vz
    logic signed [NW-1:0] r_n [3];
    logic                 r_deg;
    logic                 r_v1, r_v2;
    logic                 w_rdy2;
    logic signed [PW-1:0] w_p [6];
    logic signed [NW-1:0] w_n [3];
    logic [31:0]          w_wide [IN_FIELDS];

    // Bits above the coordinate width are ignored; a wider coordinate sees
    // the field as zero-extended.
    always_comb begin
        for (int i = 0; i < IN_FIELDS; i++) begin
            w_wide[i] = 32'(i_data[i*FIELD_W +: FIELD_W]);
            w_c[i]    = $signed(w_wide[i][COORD_WIDTH-1:0]);
        end
    end

    assign w_rdy2  = !r_v2 || i_ready;
    assign o_ready = !r_v1 || w_rdy2;

    assign w_p[0] = r_e[1] * r_e[5];
    assign w_p[1] = r_e[2] * r_e[4];
    assign w_p[2] = r_e[2] * r_e[3];
    assign w_p[3] = r_e[0] * r_e[5];
    assign w_p[4] = r_e[0] * r_e[4];
    assign w_p[5] = r_e[1] * r_e[3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_n[k] = NW'(w_p[2*k]) - NW'(w_p[2*k+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
        if (o_ready && i_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_e[k]   <= EW'(w_c[3+k]) - EW'(w_c[k]);
                r_e[3+k] <= EW'(w_c[6+k]) - EW'(w_c[k]);
            end
        end
        if (w_rdy2 && r_v1) begin
            r_n   <= w_n;
            r_deg <= (w_n[0] == '0) && (w_n[1] == '0) && (w_n[2] == '0);
        end
    end

    assign o_valid = r_v2;
    assign o_data  = {r_deg, r_n[2], r_n[1], r_n[0]};
endmodule

>>> src/tfn_queue.sv
// Short first-in first-out queue between the front and back ends.
// Depends on tfn_pkg.
module tfn_queue
    import tfn_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

>>> src/tfn_back.sv
// Back end: squared length and a pipelined restoring divide by the length.
// Depends on tfn_pkg.
module tfn_back
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
    localparam int NW = 2 * (COORD_WIDTH + 1) + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [3*NW:0]         i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data,
    output logic                  o_deg
);
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int MW  = NW - 1;
    localparam int H   = (MW + 1) / 2;
    localparam int HW  = MW - H;
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;
    localparam int RW  = SQW + 2 * F;
    localparam int TW  = SW + F + 1;
    localparam int DW  = SW + 2 * F + 2;
    localparam int QW  = F + 1;
    localparam int NS  = F + 2;

    logic w_en;

    // Stage 0: magnitudes split into halves and their partial products.
    logic             r0_v, r0_deg;
    logic             r0_neg [3];
    logic [2*HW-1:0]  r0_hh  [3];
    logic [MW-1:0]    r0_hl  [3];
    logic [2*H-1:0]   r0_ll  [3];
    // Stage 1: squares.
    logic             r1_v, r1_deg;
    logic             r1_neg [3];
    logic [SQW-1:0]   r1_sq  [3];
    // Divide stages.
    logic             r_v   [NS];
    logic             r_deg [NS];
    logic [SW-1:0]    r_s   [NS];
    logic             r_neg [NS][3];
    logic [RW-1:0]    r_rem [NS][3];
    logic [TW-1:0]    r_t   [NS][3];
    logic [QW-1:0]    r_q   [NS][3];
    logic [RW-1:0]    n_rem [NS-1][3];
    logic [TW-1:0]    n_t   [NS-1][3];
    logic [QW-1:0]    n_q   [NS-1][3];
    logic             r_out_v, r_out_deg;
    logic [FIELD_W-1:0] r_out [3];

    logic signed [NW-1:0] w_n   [3];
    logic [NW-1:0]        w_abs [3];
    logic [MW-1:0]        w_mag [3];
    logic [DW-1:0]        w_d   [NS-1][3];
    logic [31:0]          w_sv  [3];

    // The whole back end moves as one pipeline, held while the output stalls.
    assign w_en    = !r_out_v || i_ready;
    assign o_ready = w_en;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_n[k]   = $signed(i_data[k*NW +: NW]);
            w_abs[k] = w_n[k][NW-1] ? NW'(-w_n[k]) : NW'(w_n[k]);
            w_mag[k] = w_abs[k][MW-1:0];
        end
    end

    // Step for bit b = F - j: with q the quotient so far, T = q*S and the
    // remainder R = n^2*4^F - q^2*S, adding 2^b costs (T<<(b+1)) + (S<<2b).
    always_comb begin
        for (int j = 0; j < NS - 1; j++) begin
            for (int k = 0; k < 3; k++) begin
                w_d[j][k] = (DW'(r_t[j][k]) << (F - j + 1)) +
                            (DW'(r_s[j]) << (2 * (F - j)));
                if (w_d[j][k] <= DW'(r_rem[j][k])) begin
                    n_rem[j][k] = r_rem[j][k] - w_d[j][k][RW-1:0];
                    n_t[j][k]   = r_t[j][k] + TW'(TW'(r_s[j]) << (F - j));
                    n_q[j][k]   = r_q[j][k] | QW'(QW'(1) << (F - j));
                end else begin
                    n_rem[j][k] = r_rem[j][k];
                    n_t[j][k]   = r_t[j][k];
                    n_q[j][k]   = r_q[j][k];
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sv[k] = 32'(r_q[NS-1][k]);
            if (r_neg[NS-1][k]) begin
                w_sv[k] = -w_sv[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v    <= 1'b0;
            r1_v    <= 1'b0;
            r_out_v <= 1'b0;
            for (int j = 0; j < NS; j++) begin
                r_v[j] <= 1'b0;
            end
        end else if (w_en) begin
            r0_v    <= i_valid;
            r1_v    <= r0_v;
            r_v[0]  <= r1_v;
            for (int j = 1; j < NS; j++) begin
                r_v[j] <= r_v[j-1];
            end
            r_out_v <= r_v[NS-1];
        end
        if (w_en) begin
            r0_deg <= i_data[3*NW];
            for (int k = 0; k < 3; k++) begin
                r0_neg[k] <= w_n[k][NW-1];
                r0_hh[k]  <= w_mag[k][MW-1:H] * w_mag[k][MW-1:H];
                r0_hl[k]  <= w_mag[k][MW-1:H] * w_mag[k][H-1:0];
                r0_ll[k]  <= w_mag[k][H-1:0] * w_mag[k][H-1:0];
            end
            r1_deg <= r0_deg;
            for (int k = 0; k < 3; k++) begin
                r1_neg[k] <= r0_neg[k];
                r1_sq[k]  <= (SQW'(r0_hh[k]) << (2 * H)) + (SQW'(r0_hl[k]) << (H + 1)) +
                             SQW'(r0_ll[k]);
            end
            r_deg[0] <= r1_deg;
            r_s[0]   <= SW'(r1_sq[0]) + SW'(r1_sq[1]) + SW'(r1_sq[2]);
            for (int k = 0; k < 3; k++) begin
                r_neg[0][k] <= r1_neg[k];
                r_rem[0][k] <= RW'(r1_sq[k]) << (2 * F);
                r_t[0][k]   <= '0;
                r_q[0][k]   <= '0;
            end
            for (int j = 1; j < NS; j++) begin
                r_deg[j] <= r_deg[j-1];
                r_s[j]   <= r_s[j-1];
                for (int k = 0; k < 3; k++) begin
                    r_neg[j][k] <= r_neg[j-1][k];
                    r_rem[j][k] <= n_rem[j-1][k];
                    r_t[j][k]   <= n_t[j-1][k];
                    r_q[j][k]   <= n_q[j-1][k];
                end
            end
            r_out_deg <= r_deg[NS-1];
            for (int k = 0; k < 3; k++) begin
                r_out[k] <= r_deg[NS-1] ? '0 : w_sv[k][FIELD_W-1:0];
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = {r_out[2], r_out[1], r_out[0]};
    assign o_deg   = r_out_deg;
endmodule

>>> src/triangle_face_normal.sv
// Top level of the triangle face normal block.
// Depends on tfn_pkg, tfn_front, tfn_queue and tfn_back.

// Accepts one triangle per clock cycle unless the output stalls, and returns
// its unit normal in signed Q1.14 (truncated toward zero), plus a degenerate
// flag when the cross product is zero. Throughput is one item per cycle while
// the output does not stall. The divide pipeline in the back end resolves one
// quotient bit per stage. A four-entry queue between the cross-product front
// end and the back end absorbs output stalls.
module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // vertex_a_x, _a_y, _a_z, _b_x, _b_y, _b_z, _c_x, _c_y, _c_z, 16 bits each
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // normal_x, normal_y, normal_z, 16 bits each
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // degenerate
    output logic                  o_m_tuser
);
    localparam int NW = 2 * (COORD_WIDTH + 1) + 1;

    logic          w_f_valid, w_f_ready, w_b_valid, w_b_ready;
    logic [3*NW:0] w_f_data, w_b_data;

    tfn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_data  (w_f_data)
    );

    tfn_queue #(.W(3 * NW + 1), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_data),
        .o_valid (w_b_valid),
        .i_ready (w_b_ready),
        .o_data  (w_b_data)
    );

    tfn_back #(
        .COORD_WIDTH      (COORD_WIDTH),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_b_valid),
        .o_ready (w_b_ready),
        .i_data  (w_b_data),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_deg   (o_m_tuser)
    );
endmodule

>>> test/triangle_face_normal_tb.sv
// Self-checking testbench for the triangle face normal block.
// Drives random and corner-case triangles and checks each normal with a predictor.
// Depends on tfn_pkg and triangle_face_normal.
`timescale 1ns / 1ps

class normal_scoreboard;
    logic [47:0] expected_q[$];
    logic        expected_deg_q[$];
    int          errors;

    // Appends one expected normal and its degenerate flag.
    function void add_expected(logic [47:0] data, logic deg);
        expected_q     = {expected_q, data};
        expected_deg_q = {expected_deg_q, deg};
    endfunction

    // Largest q <= 2^F with q^2 * sum <= n^2 * 2^(2F), then the sign of the component.
    function automatic logic [15:0] unit_component(logic signed [40:0] n, logic [127:0] sum);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [40:0]  mag;
        logic [15:0]  q;
        logic [15:0]  cand;
        mag = n < 0 ? -n : n;
        rhs = ({87'd0, mag} * {87'd0, mag}) << 28;
        q = '0;
        for (int b = 14; b >= 0; b--) begin
            cand = q | (16'd1 << b);
            lhs = {112'd0, cand} * {112'd0, cand} * sum;
            if (lhs <= rhs) q = cand;
        end
        return n < 0 ? -q : q;
    endfunction

    function void note_triangle(logic [143:0] tri_data);
        logic signed [40:0]  c[9];
        logic signed [40:0]  ux, uy, uz, vx, vy, vz;
        logic signed [40:0]  nx, ny, nz;
        logic signed [127:0] wx, wy, wz;
        logic [127:0]        sum;
        for (int i = 0; i < 9; i++) c[i] = $signed(tri_data[16*i +: 16]);
        ux = c[3] - c[0]; uy = c[4] - c[1]; uz = c[5] - c[2];
        vx = c[6] - c[0]; vy = c[7] - c[1]; vz = c[8] - c[2];
        nx = uy * vz - uz * vy;
        ny = uz * vx - ux * vz;
        nz = ux * vy - uy * vx;
        if (nx == 0 && ny == 0 && nz == 0) begin
            add_expected(48'd0, 1'b1);
        end else begin
            wx = 128'(nx);
            wy = 128'(ny);
            wz = 128'(nz);
            sum = wx * wx + wy * wy + wz * wz;
            add_expected({unit_component(nz, sum), unit_component(ny, sum),
                          unit_component(nx, sum)}, 1'b0);
        end
    endfunction

    function void check_normal(logic [47:0] data, logic deg);
        logic [47:0] exp_data;
        logic        exp_deg;
        if (expected_q.size() == 0) begin
            $error("normal transfer with no triangle pending");
            errors++;
            return;
        end
        exp_data = expected_q.pop_front();
        exp_deg = expected_deg_q.pop_front();
        if (data[15:0] !== exp_data[15:0]) begin
            $error("normal_x expected %0h actual %0h", exp_data[15:0], data[15:0]);
            errors++;
        end
        if (data[31:16] !== exp_data[31:16]) begin
            $error("normal_y expected %0h actual %0h", exp_data[31:16], data[31:16]);
            errors++;
        end
        if (data[47:32] !== exp_data[47:32]) begin
            $error("normal_z expected %0h actual %0h", exp_data[47:32], data[47:32]);
            errors++;
        end
        if (deg !== exp_deg) begin
            $error("degenerate expected %0b actual %0b", exp_deg, deg);
            errors++;
        end
    endfunction
endclass

module triangle_face_normal_tb
    import tfn_pkg::*;
();
    localparam int RANDOM_TRIANGLES = 880;
    localparam int STALL_LIMIT      = 2000;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_s_tvalid = 0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;

    normal_scoreboard sb = new();
    bit               quiet_phase = 0;
    bit               stim_done = 0;
    int               idle_cycles = 0;

    triangle_face_normal DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Sends one triangle; a random gap may precede it.
    task automatic send_triangle(logic [143:0] tri_data);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_s_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata  <= tri_data;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_triangle(tri_data);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 16'(32'h8000 + $urandom_range(0, 3));
            1: return 16'(32'h7fff - $urandom_range(0, 3));
            2: return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [15:0]  v[9];
        logic [143:0] t;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Extremes, axis-aligned normals and degenerate triangles first.
        send_triangle('0);
        send_triangle({9{16'h8000}});
        send_triangle({9{16'h7fff}});
        send_triangle({16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 48'h0}); // +z
        send_triangle({16'h0, 16'h0, 16'h0100, 16'h0, 16'h0100, 16'h0, 48'h0}); // -z
        send_triangle({16'h0100, 32'h0, 16'h0, 16'h0, 16'h0100, 48'h0});
        send_triangle({32'h0, 16'h0100, 16'h0100, 32'h0, 48'h0});
        send_triangle({16'h7fff, 32'h0, 16'h0, 16'h7fff, 16'h0, 16'h8000, 32'h0});
        send_triangle({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                       16'h8000, 16'h8000, 16'h7fff});
        send_triangle({16'h0300, 16'h0200, 16'h0100, 16'h0600, 16'h0400, 16'h0200, 48'h0});
        send_triangle({16'hffff, 16'h0001, 16'h8000, 16'h0001, 16'h7fff, 16'hffff,
                       16'h0, 16'h8000, 16'h7fff});
        for (int n = 0; n < RANDOM_TRIANGLES; n++) begin
            if (n > RANDOM_TRIANGLES - 150) quiet_phase = 1;
            for (int i = 0; i < 9; i++) v[i] = rand_coord();
            // Some collinear triangles: C repeats A.
            if ($urandom_range(0, 15) == 0) begin
                v[6] = v[0]; v[7] = v[1]; v[8] = v[2];
            end
            for (int i = 0; i < 9; i++) t[16*i +: 16] = v[i];
            send_triangle(t);
        end
        i_s_tvalid <= 0;
        stim_done = 1;
    end

    // Output side: random stall bursts, none near the end.
    initial begin
        int burst;
        @(posedge i_rst_n);
        forever begin
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 5);
                i_m_tready <= 0;
                repeat (burst) @(posedge i_clk);
            end
            i_m_tready <= 1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_normal(o_m_tdata, o_m_tuser);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (NORMAL_FRAC_BITS_DEF + 20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
